// ===== design/ltcr_pkg.sv =====
// Shared types, constants and font table for the LCD text cell renderer.
package ltcr_pkg;

    // Result kinds carried on the master tuser
    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_PARAM = 2'd1,
        KIND_PIXEL = 2'd2
    } ltcr_kind_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

    localparam logic [15:0] FG_RESET = 16'hFFFF;
    localparam logic [15:0] BG_RESET = 16'h0000;

    // Panel command bytes
    localparam logic [7:0] OP_COL_ADDR = 8'h2A;
    localparam logic [7:0] OP_ROW_ADDR = 8'h2B;
    localparam logic [7:0] OP_MEM_WR   = 8'h2C;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] X_WRAP_LIMIT = 8'd235;
    localparam logic [7:0] Y_HOME_LIMIT = 8'd232;
    localparam logic [7:0] CELL_W       = 8'd6;
    localparam logic [7:0] CELL_H       = 8'd8;
    localparam logic [7:0] WIN_X_SPAN   = 8'd5;
    localparam logic [7:0] WIN_Y_SPAN   = 8'd7;

    // Beat sequence: 11 header beats then 48 pixels
    localparam int unsigned HDR_BEATS   = 11;
    localparam int unsigned TOTAL_BEATS = 59;
    localparam int unsigned STEP_W      = $clog2(TOTAL_BEATS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_BEATS - 1);

    localparam int unsigned GLYPH_W = 40;
    localparam logic [2:0]  PAD_COL = 3'd5;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic              last;
        logic [STEP_W-1:0] step;
    } ltcr_cmd_t;

    typedef struct packed {
        logic draws;
        logic out_free;
    } ltcr_sts_t;

    // 5x8 font, eight 5-bit rows per glyph, first row in the top bits
    function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [7:0] code);
        logic [GLYPH_W-1:0] g;
        unique case (code)
            8'h20: g = 40'h0000000000;
            8'h21: g = 40'h2108401000;
            8'h22: g = 40'h5294000000;
            8'h23: g = 40'h5295F57D4A;
            8'h24: g = 40'h23E8E2F880;
            8'h25: g = 40'hC644444C60;
            8'h26: g = 40'h64A88AC9A0;
            8'h27: g = 40'h6110000000;
            8'h28: g = 40'h1110841040;
            8'h29: g = 40'h4104211100;
            8'h2A: g = 40'h012AEA9000;
            8'h2B: g = 40'h0108E21000;
            8'h2C: g = 40'h0000061100;
            8'h2D: g = 40'h0001F00000;
            8'h2E: g = 40'h0000006300;
            8'h2F: g = 40'h0044444000;
            8'h30: g = 40'h74675CC5C0;
            8'h31: g = 40'h23084211C0;
            8'h32: g = 40'h74422223E0;
            8'h33: g = 40'hF88820C5C0;
            8'h34: g = 40'h11952F8840;
            8'h35: g = 40'hFC3C10C5C0;
            8'h36: g = 40'h3211E8C5C0;
            8'h37: g = 40'hF844442100;
            8'h38: g = 40'h7462E8C5C0;
            8'h39: g = 40'h7462F08980;
            8'h3A: g = 40'h0318063000;
            8'h3B: g = 40'h0318061100;
            8'h3C: g = 40'h1111041040;
            8'h3D: g = 40'h003E0F8000;
            8'h3E: g = 40'h4104111100;
            8'h3F: g = 40'h7442220080;
            8'h40: g = 40'h7442DAD5C0;
            8'h41: g = 40'h74631FC620;
            8'h42: g = 40'hF463E8C7C0;
            8'h43: g = 40'h74610845C0;
            8'h44: g = 40'hE4A318CB80;
            8'h45: g = 40'hFC21E843E0;
            8'h46: g = 40'hFC21E84200;
            8'h47: g = 40'h746178C5E0;
            8'h48: g = 40'h8C63F8C620;
            8'h49: g = 40'h71084211C0;
            8'h4A: g = 40'h3884214980;
            8'h4B: g = 40'h8CA98A4A20;
            8'h4C: g = 40'h84210843E0;
            8'h4D: g = 40'h8EEB58C620;
            8'h4E: g = 40'h8C7359C620;
            8'h4F: g = 40'h746318C5C0;
            8'h50: g = 40'hF463E84200;
            8'h51: g = 40'h74631AC9A0;
            8'h52: g = 40'hF463EA4A20;
            8'h53: g = 40'h7420E087C0;
            8'h54: g = 40'hF908421080;
            8'h55: g = 40'h8C6318C5C0;
            8'h56: g = 40'h8C6318A880;
            8'h57: g = 40'h8C635AD540;
            8'h58: g = 40'h8C54454620;
            8'h59: g = 40'h8C62A21080;
            8'h5A: g = 40'hF8444443E0;
            8'h5B: g = 40'h72108421C0;
            8'h5C: g = 40'h8ABE4F9080;
            8'h5D: g = 40'h70842109C0;
            8'h5E: g = 40'h22A2000000;
            8'h5F: g = 40'h00000003E0;
            8'h60: g = 40'h4104000000;
            8'h61: g = 40'h001C17C5E0;
            8'h62: g = 40'h842D98C7C0;
            8'h63: g = 40'h001D0845C0;
            8'h64: g = 40'h085B38C5E0;
            8'h65: g = 40'h001D1FC1C0;
            8'h66: g = 40'h3251C42100;
            8'h67: g = 40'h03E31785C0;
            8'h68: g = 40'h842D98C620;
            8'h69: g = 40'h20184211C0;
            8'h6A: g = 40'h100C214980;
            8'h6B: g = 40'h84254C5240;
            8'h6C: g = 40'h61084211C0;
            8'h6D: g = 40'h00355AC620;
            8'h6E: g = 40'h002D98C620;
            8'h6F: g = 40'h001D18C5C0;
            8'h70: g = 40'h003D1F4200;
            8'h71: g = 40'h001B378420;
            8'h72: g = 40'h002D984200;
            8'h73: g = 40'h001D0707C0;
            8'h74: g = 40'h42388424C0;
            8'h75: g = 40'h002318CDA0;
            8'h76: g = 40'h002318A880;
            8'h77: g = 40'h00231AD540;
            8'h78: g = 40'h0022A22A20;
            8'h79: g = 40'h00231785C0;
            8'h7A: g = 40'h003E2223E0;
            8'h7B: g = 40'h1108821040;
            8'h7C: g = 40'h2108421080;
            8'h7D: g = 40'h4108221100;
            8'h7E: g = 40'h0011510000;
            // non-printable codes draw a solid block
            default: g = '1;
        endcase
        return g;
    endfunction

endpackage

// ===== design/ltcr_ctrl.sv =====
// Sequencer FSM: takes items and steps through the beats of one character cell.
module ltcr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ltcr_pkg::ltcr_sts_t sts,
    output ltcr_pkg::ltcr_cmd_t cmd
);
    import ltcr_pkg::*;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } ltcr_state_t;

    ltcr_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.last   = (step_reg == LAST_STEP);
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load  = 1'b1;
                    step_next = '0;
                    if (sts.draws)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit  = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> step_reg <= LAST_STEP)
        else $error("step counter past last beat");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after last beat");

    a_emit_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EMIT) |-> step_reg == '0)
        else $error("cell sequence did not start at first beat");

endmodule

// ===== design/ltcr_dp.sv =====
// Datapath: cursor, colors, glyph shifter and output beat register.
module ltcr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [ltcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              in_cmd,
    input  logic [7:0]                        in_char_code,
    input  logic [7:0]                        in_pos_x,
    input  logic [7:0]                        in_pos_y,
    input  ltcr_pkg::ltcr_cmd_t               cmd,
    output ltcr_pkg::ltcr_sts_t               sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import ltcr_pkg::*;

    // header beat positions
    localparam logic [STEP_W-1:0] S_COL_OP = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_XS_HI  = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_XS_LO  = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_XE_HI  = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_XE_LO  = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_ROW_OP = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_YS_HI  = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_YS_LO  = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_YE_HI  = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_YE_LO  = STEP_W'(9);
    localparam logic [STEP_W-1:0] S_WR_OP  = STEP_W'(HDR_BEATS - 1);

    logic [7:0]         cursor_x_reg, cursor_y_reg;
    logic [15:0]        fg_reg, bg_reg;
    logic [7:0]         win_x_reg, win_y_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [2:0]         col_reg;
    logic               m_tvalid_reg;
    ltcr_kind_t         m_kind_reg;
    logic [15:0]        m_value_reg;
    logic               m_last_reg;

    // wrap and home adjust of the cursor before printing
    logic       x_wrap, y_home;
    logic [7:0] x_pre, y_pre, x_adj, y_adj;
    logic       is_newline;

    ltcr_kind_t  beat_kind;
    logic [15:0] beat_value;
    logic        is_pixel, is_pad;

    assign x_wrap     = (cursor_x_reg > X_WRAP_LIMIT);
    assign x_pre      = x_wrap ? 8'd0 : cursor_x_reg;
    assign y_pre      = x_wrap ? (cursor_y_reg + CELL_H) : cursor_y_reg;
    assign y_home     = (y_pre > Y_HOME_LIMIT);
    assign x_adj      = y_home ? 8'd0 : x_pre;
    assign y_adj      = y_home ? 8'd0 : y_pre;
    assign is_newline = (in_char_code == CHAR_NEWLINE);

    assign sts.draws    = !in_cmd && !is_newline;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign is_pixel = (cmd.step > S_WR_OP);
    assign is_pad   = (col_reg == PAD_COL);

    always_comb
    begin
        beat_kind  = KIND_PARAM;
        beat_value = '0;
        unique case (cmd.step)
            S_COL_OP: begin beat_kind = KIND_CMD; beat_value = {8'h00, OP_COL_ADDR}; end
            S_XS_HI:  beat_value = '0;
            S_XS_LO:  beat_value = {8'h00, win_x_reg};
            S_XE_HI:  beat_value = '0;
            S_XE_LO:  beat_value = {8'h00, 8'(win_x_reg + WIN_X_SPAN)};
            S_ROW_OP: begin beat_kind = KIND_CMD; beat_value = {8'h00, OP_ROW_ADDR}; end
            S_YS_HI:  beat_value = '0;
            S_YS_LO:  beat_value = {8'h00, win_y_reg};
            S_YE_HI:  beat_value = '0;
            S_YE_LO:  beat_value = {8'h00, 8'(win_y_reg + WIN_Y_SPAN)};
            S_WR_OP:  begin beat_kind = KIND_CMD; beat_value = {8'h00, OP_MEM_WR}; end
            default:
            begin
                beat_kind  = KIND_PIXEL;
                beat_value = (!is_pad && glyph_reg[GLYPH_W-1]) ? fg_reg : bg_reg;
            end
        endcase
    end

    // control state: cursor, colors, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_FG_COLOR)
                    fg_reg <= cfg_data;
                else if (cfg_index == CFG_BG_COLOR)
                    bg_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                priority if (in_cmd)
                begin
                    cursor_x_reg <= in_pos_x;
                    cursor_y_reg <= in_pos_y;
                end
                else if (is_newline)
                begin
                    cursor_x_reg <= '0;
                    cursor_y_reg <= y_adj + CELL_H;
                end
                else
                begin
                    cursor_x_reg <= x_adj + CELL_W;
                    cursor_y_reg <= y_adj;
                end
            end
            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload: window origin, glyph shifter, output beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_x_reg <= x_adj;
            win_y_reg <= y_adj;
            glyph_reg <= glyph_lookup(in_char_code);
            col_reg   <= '0;
        end
        else if (cmd.emit && is_pixel)
        begin
            if (is_pad)
                col_reg <= '0;
            else
            begin
                col_reg   <= col_reg + 1'b1;
                glyph_reg <= {glyph_reg[GLYPH_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            m_kind_reg  <= beat_kind;
            m_value_reg <= beat_value;
            m_last_reg  <= cmd.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("beat loaded over a pending output beat");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_last_reg |-> m_kind_reg == KIND_PIXEL)
        else $error("cell ended on a non-pixel beat");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && is_pixel |-> col_reg <= PAD_COL)
        else $error("pixel column counter out of range");

endmodule

// ===== design/lcd_text_cell_renderer_core.sv =====
// Top level of the 5x8 font text cell renderer for a serial RGB565 panel.
// Each input beat either sets the text cursor (tuser high, x and y in tdata) or prints one
// character code. Set cursor and newline (0x0A) are absorbed with no output.
// Any other code produces 59 output beats: the column window command (0x2A plus four
// parameter bytes), the row window command (0x2B plus four), the memory write command
// (0x2C) and 48 RGB565 pixels for a 6x8 cell, last beat flagged by tlast. Codes outside
// 0x20..0x7E draw a solid block. The cursor wraps to the next row past column 235 and
// homes past row 232 before a print, and advances by 6 after it. A print is accepted in
// the idle state and then emits 59 beats at one per cycle while m_tready stays high; the
// rate is set by the beat sequencer, which walks one step per output beat.
// The next item is taken as soon as the final beat sits in the output register.
// Colors must be written through the cfg port only while no print is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
module lcd_text_cell_renderer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // item in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // char_code[7:0], pos_x[15:8], pos_y[23:16]
    input  logic                           s_tuser,   // cmd: 0 print, 1 set cursor
    // beats out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // value[15:0]
    output logic [1:0]                     m_tuser,   // kind[1:0]
    output logic                           m_tlast,   // last beat of a cell
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ltcr_pkg::CFG_IDX_W-1:0] cfg_index, // 0 fg_color, 1 bg_color
    input  logic [15:0]                    cfg_data
);
    import ltcr_pkg::*;

    ltcr_cmd_t cmd;
    ltcr_sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    ltcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ltcr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (s_tuser),
        .in_char_code (s_tdata[7:0]),
        .in_pos_x     (s_tdata[15:8]),
        .in_pos_y     (s_tdata[23:16]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
